FILE: sv/mcfb_pkg.sv
// ----------------------------------------------------------------------------
// mcfb_pkg
// Shared types, constants and helpers for the motor command frame builder:
// command and frame beat structs, frame layout constants, payload packing
// and the per-byte reflected crc-16 update.
// ----------------------------------------------------------------------------
package mcfb_pkg;

	// frame layout
	localparam int unsigned FRAME_LEN = 17;
	localparam int unsigned PAY_BYTES = 15;
	localparam int unsigned PAY_W     = PAY_BYTES * 8;
	localparam int unsigned IDX_W     = 5;

	localparam logic [IDX_W-1:0] CRC_LO_IDX = IDX_W'(PAY_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_LEN - 1);

	localparam logic [7:0]  HDR0     = 8'hFE;
	localparam logic [7:0]  HDR1     = 8'hEE;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	// one motor command beat
	typedef struct packed {
		logic        [3:0]  motor_id;
		logic        [3:0]  motor_status;
		logic signed [15:0] torque_set;
		logic signed [15:0] speed_set;
		logic signed [31:0] position_set;
		logic signed [15:0] position_gain;
		logic signed [15:0] speed_gain;
	} cmd_t;

	// one frame byte beat
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} frame_t;

	// first 15 frame bytes, byte 0 in the low bits
	typedef logic [PAY_W-1:0] payload_t;

	// queue status seen by the producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// lay out the command in send order, first byte lowest
	function automatic payload_t pack_payload(input cmd_t c);
		payload_t p;
		p = {c.speed_gain[7:0],    c.speed_gain[15:8],
		     c.position_gain[7:0], c.position_gain[15:8],
		     c.position_set[31:24], c.position_set[23:16],
		     c.position_set[15:8],  c.position_set[7:0],
		     c.speed_set[7:0],     c.speed_set[15:8],
		     c.torque_set[7:0],    c.torque_set[15:8],
		     c.motor_status, c.motor_id,
		     HDR1, HDR0};
		return p;
	endfunction

	// reflected crc-16 update over one byte, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
	                                         input logic [7:0]  data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/motor_command_frame_builder.sv
// ----------------------------------------------------------------------------
// motor_command_frame_builder
// Builds a 17-byte motor command frame (header, mode, setpoints, gains,
// crc-16 kermit) and sends it one byte per strobe beat.
// An accepted command passes the intake register, the queue entry and the
// serializer's payload and output registers; the serializer sends one byte
// per cycle and frames of queued commands follow with no gap.
// busy rises once the queue is full and a further command is staged.
// Reset clears the queue, the serializer and strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module motor_command_frame_builder import mcfb_pkg::*; #(
	parameter int unsigned QDEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  cmd_t   cmd,
	output logic   busy,
	output logic   strobe,
	output frame_t frame
);

	q_status_t qstat;
	logic      push;
	logic      pop;
	payload_t  push_data;
	payload_t  pop_data;

	// command intake
	mcfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	mcfb_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	// frame serializer
	mcfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.strobe   (strobe),
		.frame    (frame)
	);

endmodule

FILE: sv/mcfb_front.sv
// ----------------------------------------------------------------------------
// mcfb_front
// Command intake: takes a command beat, packs it into frame byte order and
// hands it to the queue. Holds one staged command while the queue is full.
// ----------------------------------------------------------------------------
module mcfb_front import mcfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cmd_t      cmd,
	output logic      busy,
	input  q_status_t qstat,
	output logic      push,
	output payload_t  push_data
);

	logic     vld_s1;
	payload_t pay_s1;
	logic     accept;

	// handshake with the command source and the queue
	always_comb begin
		busy   = vld_s1 && qstat.full;
		push   = vld_s1 && !qstat.full;
		accept = start && !busy;
	end

	assign push_data = pay_s1;

	// staged command valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// staged payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pay_s1 <= pack_payload(cmd);
		end
	end

endmodule

FILE: sv/mcfb_queue.sv
// ----------------------------------------------------------------------------
// mcfb_queue
// Short payload queue between the intake and the serializer so that each
// side stalls on its own.
// ----------------------------------------------------------------------------
module mcfb_queue import mcfb_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  payload_t  push_data,
	input  logic      pop,
	output payload_t  pop_data,
	output q_status_t qstat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	payload_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	// status and head entry
	always_comb begin
		qstat.full  = (cnt_q == CNT_FULL);
		qstat.empty = (cnt_q == '0);
		pop_data    = mem_q[rd_ptr_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qstat.full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

endmodule

FILE: sv/mcfb_back.sv
// ----------------------------------------------------------------------------
// mcfb_back
// Frame serializer: pulls one payload from the queue, sends its 15 bytes one
// per cycle while folding them into the crc, then the crc low and high byte.
// ----------------------------------------------------------------------------
module mcfb_back import mcfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t qstat,
	input  payload_t  pop_data,
	output logic      pop,
	output logic      strobe,
	output frame_t    frame
);

	logic              active_q;
	logic [IDX_W-1:0]  idx_q;
	payload_t          pay_q;
	logic [15:0]       crc_q;
	logic              strobe_q;
	frame_t            frame_q;
	logic              load;
	logic              at_last;
	frame_t            beat;

	// take the next payload when idle or on the last byte
	always_comb begin
		at_last = (idx_q == LAST_IDX);
		load    = (!active_q || at_last) && !qstat.empty;
		pop     = load;
	end

	// byte select for the current position
	always_comb begin
		if (idx_q < CRC_LO_IDX) begin
			beat.frame_byte = pay_q[7:0];
		end else if (idx_q == CRC_LO_IDX) begin
			beat.frame_byte = crc_q[7:0];
		end else begin
			beat.frame_byte = crc_q[15:8];
		end
		beat.frame_last = at_last;
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (active_q) begin
				if (at_last) begin
					active_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// payload shift, crc and output register
	always_ff @(posedge clk) begin
		frame_q <= beat;
		if (load) begin
			pay_q <= pop_data;
			crc_q <= CRC_INIT;
		end else if (active_q && (idx_q < CRC_LO_IDX)) begin
			pay_q <= pay_q >> 8;
			crc_q <= crc_byte(crc_q, pay_q[7:0]);
		end
	end

	assign strobe = strobe_q;
	assign frame  = frame_q;

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (active_q && idx_q == '0 && crc_q == CRC_INIT))
		else $error("frame did not restart on load");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= LAST_IDX))
		else $error("byte index past frame end");

	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && at_last) |=> (strobe && frame.frame_last))
		else $error("last byte not flagged");

endmodule

FILE: tb/motor_command_frame_builder_tb.sv
// ----------------------------------------------------------------------------
// motor_command_frame_builder_tb
// Self-checking bench for the motor command frame builder. A queue of
// directed and random commands feeds a clocked driver that honors busy and
// inserts random idle bursts. Each accepted command is expanded here into
// its 17 expected frame bytes, with a bit-serial kermit crc. A clocked
// monitor compares every strobe beat against the oldest expected byte.
// ----------------------------------------------------------------------------
module motor_command_frame_builder_tb import mcfb_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_CMDS = 300;
	localparam int unsigned CALM_TAIL   = 50;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   start  = 1'b0;
	cmd_t   cmd    = '0;
	logic   busy;
	logic   strobe;
	frame_t frame;

	cmd_t   cmds_pending[$];
	frame_t frame_bytes_due[$];

	int unsigned cmds_total     = 0;
	int unsigned cmds_directed  = 0;
	int unsigned cmds_accepted  = 0;
	int unsigned bytes_checked  = 0;
	int unsigned frames_checked = 0;
	int unsigned mismatches     = 0;
	int unsigned gap_left       = 0;
	int unsigned idle_pct       = 25;

	motor_command_frame_builder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe),
		.frame  (frame)
	);

	// clock
	always #5ns clk = ~clk;

	// mismatch report
	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// expected frame bytes for one command, crc computed bit by bit
	function automatic void predict_frame(input cmd_t c);
		logic [7:0]  fb [FRAME_LEN];
		logic [15:0] crc;
		logic        fbk;
		frame_t      beat;
		fb[0]  = HDR0;
		fb[1]  = HDR1;
		fb[2]  = {c.motor_status, c.motor_id};
		fb[3]  = c.torque_set[15:8];
		fb[4]  = c.torque_set[7:0];
		fb[5]  = c.speed_set[15:8];
		fb[6]  = c.speed_set[7:0];
		fb[7]  = c.position_set[7:0];
		fb[8]  = c.position_set[15:8];
		fb[9]  = c.position_set[23:16];
		fb[10] = c.position_set[31:24];
		fb[11] = c.position_gain[15:8];
		fb[12] = c.position_gain[7:0];
		fb[13] = c.speed_gain[15:8];
		fb[14] = c.speed_gain[7:0];
		crc = CRC_INIT;
		for (int k = 0; k < PAY_BYTES; k++) begin
			for (int b = 0; b < 8; b++) begin
				fbk = crc[0] ^ fb[k][b];
				crc = crc >> 1;
				if (fbk) begin
					crc = crc ^ CRC_POLY;
				end
			end
		end
		fb[15] = crc[7:0];
		fb[16] = crc[15:8];
		for (int k = 0; k < FRAME_LEN; k++) begin
			beat.frame_byte = fb[k];
			beat.frame_last = (k == FRAME_LEN - 1);
			frame_bytes_due.push_back(beat);
		end
	endfunction

	function automatic cmd_t mk_cmd(input logic [3:0] id, input logic [3:0] st,
	                                input logic [15:0] tq, input logic [15:0] sp,
	                                input logic [31:0] ps, input logic [15:0] kp,
	                                input logic [15:0] kd);
		cmd_t c;
		c.motor_id      = id;
		c.motor_status  = st;
		c.torque_set    = tq;
		c.speed_set     = sp;
		c.position_set  = ps;
		c.position_gain = kp;
		c.speed_gain    = kd;
		return c;
	endfunction

	// 16-bit value, mostly uniform, sometimes an extreme
	function automatic logic [15:0] pick_word();
		logic [15:0] v;
		v = 16'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				2: v = 16'h7FFF;
				default: v = 16'h8000;
			endcase
		end
		return v;
	endfunction

	function automatic logic [31:0] pick_long();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: v = 32'h0000_0000;
				1: v = 32'hFFFF_FFFF;
				2: v = 32'h7FFF_FFFF;
				default: v = 32'h8000_0000;
			endcase
		end
		return v;
	endfunction

	// driver: holds start until accepted, random idle bursts between beats
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && busy) begin
			// hold the current beat
		end else begin
			if (start) begin
				predict_frame(cmd);
				cmds_accepted++;
				if (cmds_accepted % 40 == 0) begin
					case ($urandom_range(0, 2))
						0: idle_pct = 0;
						1: idle_pct = 25;
						default: idle_pct = 60;
					endcase
				end
				if (cmds_pending.size() > CALM_TAIL &&
				    $urandom_range(0, 99) < idle_pct) begin
					gap_left = $urandom_range(1, 17);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmds_pending.size() > 0) begin
				cmd   <= cmds_pending.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobe beat against the oldest expected byte
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && strobe) begin
			if (frame_bytes_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected byte %02h last %0b",
				                        frame.frame_byte, frame.frame_last));
			end else begin
				want = frame_bytes_due.pop_front();
				bytes_checked++;
				if (want.frame_last) begin
					frames_checked++;
				end
				if (frame.frame_byte !== want.frame_byte) begin
					flag_mismatch($sformatf("frame_byte %02h, want %02h",
					                        frame.frame_byte, want.frame_byte));
				end
				if (frame.frame_last !== want.frame_last) begin
					flag_mismatch($sformatf("frame_last %0b, want %0b",
					                        frame.frame_last, want.frame_last));
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		// directed: field extremes, nibble corners, sign and byte order
		cmds_pending.push_back(mk_cmd(4'h0, 4'h0, 16'h0000, 16'h0000, 32'h0000_0000,
		                              16'h0000, 16'h0000));
		cmds_pending.push_back(mk_cmd(4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
		                              16'hFFFF, 16'hFFFF));
		cmds_pending.push_back(mk_cmd(4'h7, 4'h7, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF,
		                              16'h7FFF, 16'h7FFF));
		cmds_pending.push_back(mk_cmd(4'h8, 4'h8, 16'h8000, 16'h8000, 32'h8000_0000,
		                              16'h8000, 16'h8000));
		cmds_pending.push_back(mk_cmd(4'h0, 4'hF, 16'h0001, 16'h0000, 32'h0000_0001,
		                              16'h0000, 16'h0001));
		cmds_pending.push_back(mk_cmd(4'hF, 4'h0, 16'h0000, 16'h0001, 32'h0000_0000,
		                              16'h0001, 16'h0000));
		cmds_pending.push_back(mk_cmd(4'hA, 4'h5, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA,
		                              16'h5555, 16'hAAAA));
		cmds_pending.push_back(mk_cmd(4'h5, 4'hA, 16'h5555, 16'hAAAA, 32'h5555_5555,
		                              16'hAAAA, 16'h5555));
		// small negatives go out as two's complement bytes
		cmds_pending.push_back(mk_cmd(4'h1, 4'h2, 16'hFFFF, 16'hFF00, 32'hFFFF_FFFE,
		                              16'hFB00, 16'hFF80));
		// distinct bytes expose any byte order slip
		cmds_pending.push_back(mk_cmd(4'h3, 4'hC, 16'h0102, 16'h0304, 32'h0807_0605,
		                              16'h090A, 16'h0B0C));
		cmds_pending.push_back(mk_cmd(4'hE, 4'hF, 16'hFEEE, 16'hEEFE, 32'hFEEE_FEEE,
		                              16'hFEEE, 16'hEEFE));
		cmds_pending.push_back(mk_cmd(4'h9, 4'h6, 16'h8001, 16'h7FFE, 32'h8000_0001,
		                              16'h8000, 16'h7FFF));
		cmds_pending.push_back(mk_cmd(4'h2, 4'h1, 16'h0100, 16'h00FF, 32'h0100_00FF,
		                              16'h00FF, 16'h0100));
		cmds_pending.push_back(mk_cmd(4'hC, 4'h3, 16'h0000, 16'h0000, 32'h0000_8000,
		                              16'h0000, 16'h0000));
		cmds_directed = cmds_pending.size();

		// random commands
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			cmds_pending.push_back(mk_cmd(4'($urandom), 4'($urandom), pick_word(),
			                              pick_word(), pick_long(), pick_word(),
			                              pick_word()));
		end
		cmds_total = cmds_pending.size();

		// reset
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all commands taken, every expected byte seen
		while (cmds_accepted < cmds_total || frame_bytes_due.size() > 0) begin
			@(posedge clk);
		end
		// catch stray bytes after the last frame
		repeat (2 * FRAME_LEN + 8) @(posedge clk);

		$display("covered %0d commands (%0d directed, %0d random) with idle bursts",
		         cmds_accepted, cmds_directed, cmds_total - cmds_directed);
		$display("checked %0d frame bytes in %0d frames, %0d mismatches",
		         bytes_checked, frames_checked, mismatches);
		if (mismatches == 0) begin
			$display("PASS motor_command_frame_builder");
		end else begin
			$display("FAIL motor_command_frame_builder");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1ms;
		$display("timeout: %0d of %0d commands accepted, %0d bytes still due",
		         cmds_accepted, cmds_total, frame_bytes_due.size());
		$display("FAIL motor_command_frame_builder");
		$finish;
	end

endmodule
